/* hw/rtl/snqm_pkg.sv */
// Types and codes for the named stack/queue manager.
// Used by named_stack_queue_manager_unit; depends on nothing.
`default_nettype none

package snqm_pkg;

    localparam int KEY_W   = 16;
    localparam int VALUE_W = 32;

    localparam logic [1:0] CMD_CREATE = 2'd0;
    localparam logic [1:0] CMD_PUSH   = 2'd1;
    localparam logic [1:0] CMD_POP    = 2'd2;

    localparam logic [2:0] STAT_OK         = 3'd0;
    localparam logic [2:0] STAT_POPPED     = 3'd1;
    localparam logic [2:0] STAT_EXISTS     = 3'd2;
    localparam logic [2:0] STAT_MISSING    = 3'd3;
    localparam logic [2:0] STAT_EMPTY      = 3'd4;
    localparam logic [2:0] STAT_TABLE_FULL = 3'd5;
    localparam logic [2:0] STAT_POOL_FULL  = 3'd6;

    typedef struct packed {
        logic [1:0]               command;
        logic [KEY_W-1:0]         name_key;
        logic                     list_kind;
        logic signed [VALUE_W-1:0] data_value;
    } req_word_t;

    typedef struct packed {
        logic [2:0]                status;
        logic signed [VALUE_W-1:0] popped_value;
    } resp_word_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_ALLOC,
        ST_POP
    } state_t;

endpackage

`default_nettype wire

/* hw/rtl/named_stack_queue_manager_unit.sv */
// Named stack/queue manager: list table in flops, node pool in two RAMs.
// Depends on snqm_pkg and snqm_ram.
//
//   channel   | ports                  | handshake
//   ----------+------------------------+----------------------------------
//   request   | request (req_word_t)   | taken when start && !busy
//   response  | response (resp_word_t) | valid for one cycle while done
//
// Create and every failing command are answered from ST_EXEC; a good push
// or pop also passes through ST_ALLOC or ST_POP for the node RAM read.
// busy stays high until the result is out, so the node RAM never sees a
// read and a write of the same entry overlap. Reset clears the table and
// the pool; unused nodes are handed out by a fill counter.
// The receiver cannot stall; one word is produced per accepted word.
`default_nettype none

module named_stack_queue_manager_unit #(
    parameter int MAX_LISTS  = 16,
    parameter int POOL_NODES = 256,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire snqm_pkg::req_word_t request,
    output logic                    done,
    output snqm_pkg::resp_word_t    response
);

    import snqm_pkg::*;

    localparam int SW = (MAX_LISTS > 1) ? $clog2(MAX_LISTS) : 1;
    localparam int PW = $clog2(POOL_NODES);
    localparam int CW = $clog2(POOL_NODES + 1);

    state_t state_reg, state_next;

    req_word_t       req_reg;
    logic            hit_reg;
    logic [SW-1:0]   slot_reg;
    logic            room_reg;
    logic [SW-1:0]   room_slot_reg;

    logic [MAX_LISTS-1:0] entry_valid_reg;
    logic [KEY_W-1:0]     entry_key_reg   [MAX_LISTS];
    logic                 entry_stack_reg [MAX_LISTS];
    logic [PW-1:0]        head_reg        [MAX_LISTS];
    logic [PW-1:0]        tail_reg        [MAX_LISTS];
    logic [CW-1:0]        count_reg       [MAX_LISTS];

    logic [CW-1:0] fresh_reg;
    logic [CW-1:0] free_count_reg;
    logic [PW-1:0] rec_head_reg;
    logic [PW-1:0] node_reg;
    logic          recycled_reg;

    logic       done_reg;
    resp_word_t resp_reg;
    logic       done_next;
    resp_word_t resp_next;

    logic            match_hit;
    logic [SW-1:0]   match_slot;
    logic            free_hit;
    logic [SW-1:0]   free_slot;

    logic            is_create;
    logic            is_push;
    logic [CW-1:0]   cur_count;
    logic            cur_stack;
    logic [PW-1:0]   cur_head;
    logic [PW-1:0]   cur_tail;
    logic            fresh_avail;
    logic            count_zero;

    logic tbl_create;
    logic push_take;
    logic push_commit;
    logic pop_commit;

    logic                  data_we;
    logic [PW-1:0]         data_waddr;
    logic [DATA_WIDTH-1:0] data_wdata;
    logic [PW-1:0]         data_raddr;
    logic [DATA_WIDTH-1:0] data_rdata;
    logic                  link_we;
    logic [PW-1:0]         link_waddr;
    logic [PW-1:0]         link_wdata;
    logic [PW-1:0]         link_raddr;
    logic [PW-1:0]         link_rdata;

    snqm_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (POOL_NODES)
    ) u_data_ram (
        .clk   (clk),
        .we    (data_we),
        .waddr (data_waddr),
        .wdata (data_wdata),
        .raddr (data_raddr),
        .rdata (data_rdata)
    );

    snqm_ram #(
        .WIDTH (PW),
        .DEPTH (POOL_NODES)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    // match key and find lowest free slot
    always_comb
    begin
        match_hit  = 1'b0;
        match_slot = '0;
        free_hit   = 1'b0;
        free_slot  = '0;
        for (int i = MAX_LISTS - 1; i >= 0; i--)
        begin
            if (entry_valid_reg[i] && entry_key_reg[i] == request.name_key)
            begin
                match_hit  = 1'b1;
                match_slot = SW'(i);
            end
            if (!entry_valid_reg[i])
            begin
                free_hit  = 1'b1;
                free_slot = SW'(i);
            end
        end
    end

    assign is_create   = (req_reg.command == CMD_CREATE);
    assign is_push     = (req_reg.command == CMD_PUSH);
    assign cur_count   = count_reg[slot_reg];
    assign cur_stack   = entry_stack_reg[slot_reg];
    assign cur_head    = head_reg[slot_reg];
    assign cur_tail    = tail_reg[slot_reg];
    assign count_zero  = (cur_count == '0);
    assign fresh_avail = (fresh_reg != CW'(POOL_NODES));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (is_create || !hit_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (is_push)
                begin
                    state_next = (free_count_reg == '0) ? ST_IDLE : ST_ALLOC;
                end
                else
                begin
                    state_next = count_zero ? ST_IDLE : ST_POP;
                end
            end
            ST_ALLOC: state_next = ST_IDLE;
            ST_POP:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs and memory controls
    always_comb
    begin
        done_next   = 1'b0;
        resp_next   = '0;
        tbl_create  = 1'b0;
        push_take   = 1'b0;
        push_commit = 1'b0;
        pop_commit  = 1'b0;
        data_we     = 1'b0;
        data_waddr  = node_reg;
        data_wdata  = DATA_WIDTH'($unsigned(req_reg.data_value));
        data_raddr  = cur_head;
        link_we     = 1'b0;
        link_waddr  = node_reg;
        link_wdata  = cur_head;
        link_raddr  = cur_head;
        unique case (state_reg)
            ST_IDLE:
            begin
            end
            ST_EXEC:
            begin
                if (is_create)
                begin
                    done_next = 1'b1;
                    if (hit_reg)
                    begin
                        resp_next.status = STAT_EXISTS;
                    end
                    else if (!room_reg)
                    begin
                        resp_next.status = STAT_TABLE_FULL;
                    end
                    else
                    begin
                        resp_next.status = STAT_OK;
                        tbl_create       = 1'b1;
                    end
                end
                else if (!hit_reg)
                begin
                    done_next        = 1'b1;
                    resp_next.status = STAT_MISSING;
                end
                else if (is_push)
                begin
                    if (free_count_reg == '0)
                    begin
                        done_next        = 1'b1;
                        resp_next.status = STAT_POOL_FULL;
                    end
                    else
                    begin
                        push_take  = 1'b1;
                        link_raddr = rec_head_reg;
                    end
                end
                else if (count_zero)
                begin
                    done_next        = 1'b1;
                    resp_next.status = STAT_EMPTY;
                end
            end
            ST_ALLOC:
            begin
                done_next        = 1'b1;
                resp_next.status = STAT_OK;
                push_commit      = 1'b1;
                data_we          = 1'b1;
                if (!count_zero)
                begin
                    link_we = 1'b1;
                    if (cur_stack)
                    begin
                        link_waddr = node_reg;
                        link_wdata = cur_head;
                    end
                    else
                    begin
                        link_waddr = cur_tail;
                        link_wdata = node_reg;
                    end
                end
            end
            ST_POP:
            begin
                done_next              = 1'b1;
                resp_next.status       = STAT_POPPED;
                resp_next.popped_value = VALUE_W'(data_rdata);
                pop_commit             = 1'b1;
                link_we                = 1'b1;
                link_waddr             = cur_head;
                link_wdata             = rec_head_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            done_reg       <= 1'b0;
            fresh_reg      <= '0;
            free_count_reg <= CW'(POOL_NODES);
            rec_head_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (push_take)
            begin
                free_count_reg <= free_count_reg - 1'b1;
                if (fresh_avail)
                begin
                    fresh_reg <= fresh_reg + 1'b1;
                end
            end
            if (push_commit && recycled_reg)
            begin
                rec_head_reg <= link_rdata;
            end
            if (pop_commit)
            begin
                free_count_reg <= free_count_reg + 1'b1;
                rec_head_reg   <= cur_head;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        resp_reg <= resp_next;
        if (start && !busy)
        begin
            req_reg       <= request;
            hit_reg       <= match_hit;
            slot_reg      <= match_slot;
            room_reg      <= free_hit;
            room_slot_reg <= free_slot;
        end
        if (push_take)
        begin
            node_reg     <= fresh_avail ? fresh_reg[PW-1:0] : rec_head_reg;
            recycled_reg <= !fresh_avail;
        end
    end

    // hold list table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
            for (int i = 0; i < MAX_LISTS; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else
        begin
            if (tbl_create)
            begin
                entry_valid_reg[room_slot_reg] <= 1'b1;
                count_reg[room_slot_reg]       <= '0;
            end
            if (push_commit)
            begin
                count_reg[slot_reg] <= cur_count + 1'b1;
            end
            if (pop_commit)
            begin
                count_reg[slot_reg] <= cur_count - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tbl_create)
        begin
            entry_key_reg[room_slot_reg]   <= req_reg.name_key;
            entry_stack_reg[room_slot_reg] <= req_reg.list_kind;
        end
        if (push_commit)
        begin
            if (count_zero || cur_stack)
            begin
                head_reg[slot_reg] <= node_reg;
            end
            if (count_zero || !cur_stack)
            begin
                tail_reg[slot_reg] <= node_reg;
            end
        end
        if (pop_commit)
        begin
            head_reg[slot_reg] <= link_rdata;
        end
    end

    assign busy     = (state_reg != ST_IDLE);
    assign done     = done_reg;
    assign response = resp_reg;

    a_done_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == ST_IDLE))
        else $error("result strobe outside idle");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == ST_EXEC))
        else $error("accepted word did not start execution");

    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (free_count_reg <= CW'(POOL_NODES)) && (fresh_reg <= CW'(POOL_NODES)))
        else $error("pool counters out of range");

    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && resp_reg.status != STAT_POPPED) |-> (resp_reg.popped_value == '0))
        else $error("value on a result that is not a pop");

    a_pop_frees: assert property (@(posedge clk) disable iff (!rst_n)
        pop_commit |=> (free_count_reg == $past(free_count_reg) + 1'b1))
        else $error("pop did not return a node to the pool");

endmodule

`default_nettype wire

/* hw/rtl/snqm_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
`default_nettype none

module snqm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* sim/tb_named_stack_queue_manager_unit.sv */
// Self-checking testbench for named_stack_queue_manager_unit: predicts each
// response from a local copy of the list table and node pool.
// Depends on snqm_pkg and the unit under test.
`timescale 1ns / 100ps

module tb_named_stack_queue_manager_unit;

    import snqm_pkg::*;

    localparam int LISTS    = 16;
    localparam int NODES    = 256;
    localparam int KEY_BANK = 24;

    localparam logic [1:0] CMD_POP_ALIAS = 2'd3;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic       done;
    req_word_t  request;
    resp_word_t response;

    named_stack_queue_manager_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .request  (request),
        .done     (done),
        .response (response)
    );

    always #5 clk = ~clk;

    logic                     list_used  [LISTS];
    logic [KEY_W-1:0]         list_key   [LISTS];
    logic                     list_lifo  [LISTS];
    logic [7:0]               list_first [LISTS];
    logic [7:0]               list_last  [LISTS];
    int unsigned              list_len   [LISTS];
    logic signed [VALUE_W-1:0] node_val  [NODES];
    logic [7:0]               node_link  [NODES];
    logic [7:0]               free_first;
    int unsigned              free_len;

    logic [KEY_W-1:0] key_bank [KEY_BANK];
    resp_word_t       pending_results [$];
    int               mismatch_count = 0;
    int               burst_left = 0;

    function automatic int lookup_list(input logic [KEY_W-1:0] key);
        int i;
        for (i = 0; i < LISTS; i++)
            if (list_used[i] && list_key[i] == key)
                return i;
        return -1;
    endfunction

    function automatic resp_word_t apply_command(input req_word_t w);
        resp_word_t r;
        int         slot;
        int         open_slot;
        int         i;
        logic [7:0] n;
        r.status       = STAT_OK;
        r.popped_value = '0;
        slot = lookup_list(w.name_key);
        if (w.command == CMD_CREATE)
        begin
            open_slot = -1;
            for (i = LISTS - 1; i >= 0; i--)
                if (!list_used[i])
                    open_slot = i;
            if (slot >= 0)
            begin
                r.status = STAT_EXISTS;
            end
            else if (open_slot < 0)
            begin
                r.status = STAT_TABLE_FULL;
            end
            else
            begin
                list_used[open_slot]  = 1'b1;
                list_key[open_slot]   = w.name_key;
                list_lifo[open_slot]  = w.list_kind;
                list_len[open_slot]   = 0;
                list_first[open_slot] = '0;
                list_last[open_slot]  = '0;
            end
        end
        else if (w.command == CMD_PUSH)
        begin
            if (slot < 0)
            begin
                r.status = STAT_MISSING;
            end
            else if (free_len == 0)
            begin
                r.status = STAT_POOL_FULL;
            end
            else
            begin
                n = free_first;
                free_first = node_link[n];
                free_len--;
                node_val[n] = w.data_value;
                if (list_len[slot] == 0)
                begin
                    node_link[n]     = '0;
                    list_first[slot] = n;
                    list_last[slot]  = n;
                end
                else if (list_lifo[slot])
                begin
                    node_link[n]     = list_first[slot];
                    list_first[slot] = n;
                end
                else
                begin
                    node_link[list_last[slot]] = n;
                    node_link[n]               = '0;
                    list_last[slot]            = n;
                end
                list_len[slot]++;
            end
        end
        else
        begin
            if (slot < 0)
            begin
                r.status = STAT_MISSING;
            end
            else if (list_len[slot] == 0)
            begin
                r.status = STAT_EMPTY;
            end
            else
            begin
                n = list_first[slot];
                r.popped_value   = node_val[n];
                list_first[slot] = node_link[n];
                node_link[n]     = free_first;
                free_first       = n;
                free_len++;
                list_len[slot]--;
                r.status = STAT_POPPED;
            end
        end
        return r;
    endfunction

    function automatic req_word_t build_request(input logic [1:0] cmd,
                                                input logic [KEY_W-1:0] key,
                                                input logic kind,
                                                input logic signed [VALUE_W-1:0] value);
        req_word_t w;
        w.command    = cmd;
        w.name_key   = key;
        w.list_kind  = kind;
        w.data_value = value;
        return w;
    endfunction

    function automatic logic signed [VALUE_W-1:0] random_value();
        logic signed [VALUE_W-1:0] v;
        v = $urandom;
        if ($urandom_range(0, 15) == 0)
        begin
            case ($urandom_range(0, 3))
                0: v = 32'h8000_0000;
                1: v = 32'h7FFF_FFFF;
                2: v = 32'h0000_0000;
                default: v = 32'hFFFF_FFFF;
            endcase
        end
        return v;
    endfunction

    task automatic send_word(input req_word_t w);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                @(negedge clk);
                start <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        start   <= 1'b1;
        request <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.insert(pending_results.size(), apply_command(w));
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat ($urandom_range(1, 4)) @(posedge clk);
    endtask

    task automatic test_directed();
        send_word(build_request(CMD_POP, 16'h0000, 1'b0, random_value()));
        send_word(build_request(CMD_PUSH, 16'h0000, 1'b1, 32'h1111_2222));
        send_word(build_request(CMD_CREATE, 16'h0000, 1'b0, random_value()));
        send_word(build_request(CMD_CREATE, 16'h0000, 1'b1, random_value()));
        send_word(build_request(CMD_CREATE, 16'hFFFF, 1'b1, random_value()));
        send_word(build_request(CMD_POP, 16'h0000, 1'b0, random_value()));
        send_word(build_request(CMD_POP_ALIAS, 16'hFFFF, 1'b1, random_value()));
        send_word(build_request(CMD_PUSH, 16'h0000, 1'b0, 32'h8000_0000));
        send_word(build_request(CMD_PUSH, 16'h0000, 1'b1, 32'h7FFF_FFFF));
        send_word(build_request(CMD_PUSH, 16'h0000, 1'b0, 32'hFFFF_FFFF));
        send_word(build_request(CMD_PUSH, 16'hFFFF, 1'b0, 32'h8000_0000));
        send_word(build_request(CMD_PUSH, 16'hFFFF, 1'b1, 32'h7FFF_FFFF));
        send_word(build_request(CMD_PUSH, 16'hFFFF, 1'b0, 32'h0000_0000));
        repeat (3) send_word(build_request(CMD_POP, 16'h0000, 1'b0, random_value()));
        send_word(build_request(CMD_POP, 16'hFFFF, 1'b0, random_value()));
        send_word(build_request(CMD_POP_ALIAS, 16'hFFFF, 1'b1, 32'hFFFF_FFFF));
        send_word(build_request(CMD_POP, 16'hFFFF, 1'b0, random_value()));
        send_word(build_request(CMD_POP, 16'h0000, 1'b0, random_value()));
        send_word(build_request(CMD_PUSH, 16'h1234, 1'b0, random_value()));
        send_word(build_request(CMD_POP_ALIAS, 16'h1234, 1'b0, random_value()));
    endtask

    task automatic test_random_mix(input int count);
        int               push_pct;
        int               seg_left;
        int               pick;
        int               i;
        logic [KEY_W-1:0] key;
        seg_left = 0;
        push_pct = 50;
        for (i = 0; i < count; i++)
        begin
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(40, 250);
                case ($urandom_range(0, 2))
                    0: push_pct = 30;
                    1: push_pct = 50;
                    default: push_pct = 72;
                endcase
            end
            seg_left--;
            if (i % 400 == 399)
                wait_drained();
            key  = ($urandom_range(0, 9) == 0) ? KEY_W'($urandom)
                                               : key_bank[$urandom_range(0, KEY_BANK - 1)];
            pick = $urandom_range(0, 99);
            if (pick < 6)
                send_word(build_request(CMD_CREATE, key, 1'($urandom), random_value()));
            else if (pick < 6 + push_pct)
                send_word(build_request(CMD_PUSH, key, 1'($urandom), random_value()));
            else if (pick < 95)
                send_word(build_request(CMD_POP, key, 1'($urandom), random_value()));
            else
                send_word(build_request(CMD_POP_ALIAS, key, 1'($urandom), random_value()));
        end
    endtask

    task automatic test_table_fill();
        logic [KEY_W-1:0] key;
        int               i;
        int               used;
        used = 0;
        for (i = 0; i < LISTS; i++)
            if (list_used[i])
                used++;
        while (used < LISTS + 2)
        begin
            key = KEY_W'($urandom);
            if (lookup_list(key) < 0)
            begin
                send_word(build_request(CMD_CREATE, key, 1'($urandom), random_value()));
                used++;
            end
        end
        for (i = 0; i < LISTS; i++)
            if (list_used[i])
            begin
                send_word(build_request(CMD_CREATE, list_key[i], 1'($urandom),
                                        random_value()));
                break;
            end
    endtask

    task automatic test_pool_exhaust();
        int slot;
        int extra;
        extra = 0;
        while (extra < 4)
        begin
            if (free_len == 0)
                extra++;
            slot = $urandom_range(0, LISTS - 1);
            if (list_used[slot])
                send_word(build_request(CMD_PUSH, list_key[slot], 1'($urandom),
                                        random_value()));
        end
        wait_drained();
        for (slot = 0; slot < LISTS; slot++)
        begin
            if (list_used[slot])
            begin
                while (list_len[slot] != 0)
                    send_word(build_request(($urandom_range(0, 7) == 0) ? CMD_POP_ALIAS
                                                                        : CMD_POP,
                                            list_key[slot], 1'($urandom), random_value()));
                send_word(build_request(CMD_POP, list_key[slot], 1'($urandom),
                                        random_value()));
            end
        end
    endtask

    always @(posedge clk)
    begin : check_results
        resp_word_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result status %0d value %0d",
                         $time, response.status, response.popped_value);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (response.status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, response.status);
                    mismatch_count++;
                end
                if (response.popped_value !== want.popped_value)
                begin
                    $display("%0t: popped_value expected %0d actual %0d",
                             $time, want.popped_value, response.popped_value);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin : main
        int i;
        int j;
        int waited;
        logic fresh;
        rst_n   = 1'b0;
        start   = 1'b0;
        request = '0;
        for (i = 0; i < LISTS; i++)
        begin
            list_used[i]  = 1'b0;
            list_key[i]   = '0;
            list_lifo[i]  = 1'b0;
            list_first[i] = '0;
            list_last[i]  = '0;
            list_len[i]   = 0;
        end
        for (i = 0; i < NODES; i++)
        begin
            node_val[i]  = '0;
            node_link[i] = 8'((i + 1) % NODES);
        end
        free_first = '0;
        free_len   = NODES;
        key_bank[0] = 16'h0000;
        key_bank[1] = 16'hFFFF;
        i = 2;
        while (i < KEY_BANK)
        begin
            key_bank[i] = KEY_W'($urandom);
            fresh = 1'b1;
            for (j = 0; j < i; j++)
                if (key_bank[j] == key_bank[i])
                    fresh = 1'b0;
            if (fresh)
                i++;
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed();
        test_random_mix(1100);
        test_table_fill();
        test_pool_exhaust();
        test_random_mix(150);

        @(negedge clk);
        start <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < 1000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, pending_results.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/snqm_pkg.sv
hw/rtl/snqm_ram.sv
hw/rtl/named_stack_queue_manager_unit.sv
sim/tb_named_stack_queue_manager_unit.sv
